### rtl/rsi_pkg.sv
// Shared constants and types for the row stencil iterator.
// Used by rsi_ctrl, rsi_datapath and row_stencil_iterator; no dependencies.
package rsi_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  // Fixed port widths
  localparam int VALUE_BITS      = 24;
  localparam int COLUMN_BITS     = 6;
  localparam int ROW_LENGTH_BITS = 7;
  localparam int ITER_BITS       = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_COUNT = 2'd1;

  // Register reset values
  localparam logic [ROW_LENGTH_BITS-1:0] ROW_LENGTH_RESET      = 7'd64;
  localparam logic [ITER_BITS-1:0]       ITERATION_COUNT_RESET = 16'd10;

  // Shortest row the stencil handles
  localparam int MIN_LENGTH = 3;

  // Stencil weights over 500, oldest tap (j-2) first
  localparam int WIN_TAPS   = 5;
  localparam int W_M2       = 160;
  localparam int W_M1       = 155;
  localparam int W_C0       = 100;
  localparam int W_P1       = 60;
  localparam int W_P2       = 25;
  localparam int ROUND_BIAS = 250;
  // acc/500 is taken as (acc>>2)/125
  localparam int QUOT_DIVISOR = 125;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_we;     // write the loaded sample
    logic rd_en;       // read the source row
    logic emit;        // the read is a result, not a sweep tap
    logic last;        // final column of the emitted row
    logic sweep_init;  // clear window and column count
    logic swap;        // exchange source and destination rows
    logic row_init;    // source row back to buffer A
  } rsi_cmd_t;

endpackage

### rtl/row_stencil_iterator.sv
// Row stencil iterator: loads a row, runs periodic five-point stencil sweeps,
// emits the row. Depends on rsi_pkg, rsi_ctrl and rsi_datapath.
//
// Usage:
//   Input: an item (one sample, in_value) is taken at a clock edge with start
//   high and busy low. Samples arrive in column order, one per cycle at most.
//   The sample that completes the row raises busy. Then iteration_count
//   sweeps run, and len_eff results follow on consecutive cycles, each
//   marked by result_valid for one cycle with out_value, out_column, and
//   last_flag on the final column. Results cannot be held off.
//   Timing: each sweep reads the source row memory once per cycle for
//   len_eff + 4 taps, then the sum/divide pipeline drains before the next
//   sweep reads the rows it wrote. Emission reads one column per cycle
//   through a registered read; busy drops as the last result is shown, so
//   the next row may start loading in that cycle.
//   Configuration: wr_en/wr_index/wr_data, written while the block is idle.
//   Reset: rst (synchronous) returns to loading with an empty row, row_length
//   64 and iteration_count 10. The row memories are not cleared.
module row_stencil_iterator #(
  parameter int MAX_COLUMNS = rsi_pkg::DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS = rsi_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rsi_pkg::VALUE_BITS-1:0]        in_value,
  output logic                                  result_valid,
  output logic [rsi_pkg::VALUE_BITS-1:0]        out_value,
  output logic [rsi_pkg::COLUMN_BITS-1:0]       out_column,
  output logic                                  last_flag,
  input  logic                                  wr_en,
  input  logic [rsi_pkg::CFG_INDEX_BITS-1:0]    wr_index,
  input  logic [rsi_pkg::CFG_DATA_BITS-1:0]     wr_data
);
  import rsi_pkg::*;

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int LENW = $clog2(MAX_COLUMNS + 1);
  localparam int CMPW = (ROW_LENGTH_BITS > LENW) ? ROW_LENGTH_BITS : LENW;

  logic [ROW_LENGTH_BITS-1:0] row_length;
  logic [ITER_BITS-1:0]       iteration_count;
  logic [LENW-1:0]            len_eff;
  rsi_cmd_t                   cmd;
  logic                       pipe_empty;
  logic [CW-1:0]              load_addr;
  logic [CW-1:0]              rd_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length      <= ROW_LENGTH_RESET;
      iteration_count <= ITERATION_COUNT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROW_LENGTH:      row_length      <= wr_data[ROW_LENGTH_BITS-1:0];
        REG_ITERATION_COUNT: iteration_count <= wr_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective length clamped to 3 .. MAX_COLUMNS
  always_comb begin
    if (row_length < ROW_LENGTH_BITS'(MIN_LENGTH)) begin
      len_eff = LENW'(MIN_LENGTH);
    end else if (CMPW'(row_length) > CMPW'(MAX_COLUMNS)) begin
      len_eff = LENW'(MAX_COLUMNS);
    end else begin
      len_eff = LENW'(row_length);
    end
  end

  rsi_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .len        (len_eff),
    .iter       (iteration_count),
    .pipe_empty (pipe_empty),
    .cmd        (cmd),
    .load_addr  (load_addr),
    .rd_addr    (rd_addr)
  );

  rsi_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .load_addr    (load_addr),
    .rd_addr      (rd_addr),
    .in_value     (in_value),
    .pipe_empty   (pipe_empty),
    .result_valid (result_valid),
    .out_value    (out_value),
    .out_column   (out_column),
    .last_flag    (last_flag)
  );

  // Checks
  a_swap_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.swap |-> pipe_empty)
    else $error("rows swapped while a sweep write is in flight");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.emit) |=> result_valid)
    else $error("emit read did not produce a result");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_flag) |-> busy)
    else $error("block idle before the last result");

  a_no_sweep_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && !pipe_empty))
    else $error("emission started with the sweep pipeline busy");

endmodule

### rtl/rsi_ctrl.sv
// Controller for the row stencil iterator: load, sweep, drain and emit sequencing.
// Depends on rsi_pkg; drives rsi_datapath through rsi_cmd_t.
module rsi_ctrl #(
  parameter int MAX_COLUMNS = rsi_pkg::DEF_MAX_COLUMNS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]       len,
  input  logic [rsi_pkg::ITER_BITS-1:0]          iter,
  input  logic                                   pipe_empty,
  output rsi_pkg::rsi_cmd_t                      cmd,
  output logic [$clog2(MAX_COLUMNS)-1:0]         load_addr,
  output logic [$clog2(MAX_COLUMNS)-1:0]         rd_addr
);
  import rsi_pkg::*;

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int LENW = $clog2(MAX_COLUMNS + 1);
  localparam int RW   = $clog2(MAX_COLUMNS + WIN_TAPS);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [LENW-1:0]       load_cnt, load_cnt_next;
  logic [ITER_BITS-1:0]  sweep_cnt, sweep_cnt_next;
  logic [RW-1:0]         rd_cnt, rd_cnt_next;
  logic [CW-1:0]         rd_ptr, rd_ptr_next;

  logic                  room;
  logic [LENW-1:0]       cnt_inc;
  logic [CW-1:0]         sweep_first;
  logic                  ptr_at_end;
  logic [ITER_BITS-1:0]  sweep_inc;

  assign room        = load_cnt < LENW'(MAX_COLUMNS);
  assign cnt_inc     = room ? load_cnt + LENW'(1) : load_cnt;
  // First tap of a sweep is column len-2 (periodic wrap)
  assign sweep_first = CW'(len - LENW'(2));
  assign ptr_at_end  = LENW'(rd_ptr) == len - LENW'(1);
  assign sweep_inc   = sweep_cnt + ITER_BITS'(1);

  assign busy      = state != ST_LOAD;
  assign load_addr = CW'(load_cnt);
  assign rd_addr   = rd_ptr;

  // Next-state and command decode
  always_comb begin
    state_next     = state;
    load_cnt_next  = load_cnt;
    sweep_cnt_next = sweep_cnt;
    rd_cnt_next    = rd_cnt;
    rd_ptr_next    = rd_ptr;
    cmd            = '0;
    unique case (state)
      ST_LOAD: begin
        if (start) begin
          cmd.load_we = room;
          if (cnt_inc >= len) begin
            load_cnt_next  = '0;
            sweep_cnt_next = '0;
            rd_cnt_next    = '0;
            cmd.row_init   = 1'b1;
            if (iter == '0) begin
              rd_ptr_next = '0;
              state_next  = ST_EMIT;
            end else begin
              cmd.sweep_init = 1'b1;
              rd_ptr_next    = sweep_first;
              state_next     = ST_SWEEP;
            end
          end else begin
            load_cnt_next = cnt_inc;
          end
        end
      end
      ST_SWEEP: begin
        // len+4 reads: columns len-2 .. len-1, 0 .. len-1, 0, 1
        cmd.rd_en   = 1'b1;
        rd_ptr_next = ptr_at_end ? '0 : rd_ptr + CW'(1);
        rd_cnt_next = rd_cnt + RW'(1);
        if (rd_cnt == RW'(len) + RW'(WIN_TAPS - 2)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last write of the sweep
        if (pipe_empty) begin
          cmd.swap    = 1'b1;
          rd_cnt_next = '0;
          if (sweep_inc == iter) begin
            rd_ptr_next = '0;
            state_next  = ST_EMIT;
          end else begin
            sweep_cnt_next = sweep_inc;
            cmd.sweep_init = 1'b1;
            rd_ptr_next    = sweep_first;
            state_next     = ST_SWEEP;
          end
        end
      end
      ST_EMIT: begin
        cmd.rd_en   = 1'b1;
        cmd.emit    = 1'b1;
        cmd.last    = ptr_at_end;
        rd_ptr_next = rd_ptr + CW'(1);
        if (ptr_at_end) begin
          rd_ptr_next = '0;
          state_next  = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      load_cnt  <= '0;
      sweep_cnt <= '0;
      rd_cnt    <= '0;
      rd_ptr    <= '0;
    end else begin
      state     <= state_next;
      load_cnt  <= load_cnt_next;
      sweep_cnt <= sweep_cnt_next;
      rd_cnt    <= rd_cnt_next;
      rd_ptr    <= rd_ptr_next;
    end
  end

endmodule

### rtl/rsi_datapath.sv
// Datapath for the row stencil iterator: ping-pong row memories, tap window,
// weighted sum, divide by 500 by reciprocal multiply, result register.
// Depends on rsi_pkg; commanded by rsi_ctrl.
module rsi_datapath #(
  parameter int MAX_COLUMNS = rsi_pkg::DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS = rsi_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rsi_pkg::rsi_cmd_t                   cmd,
  input  logic [$clog2(MAX_COLUMNS)-1:0]      load_addr,
  input  logic [$clog2(MAX_COLUMNS)-1:0]      rd_addr,
  input  logic [rsi_pkg::VALUE_BITS-1:0]      in_value,
  output logic                                pipe_empty,
  output logic                                result_valid,
  output logic [rsi_pkg::VALUE_BITS-1:0]      out_value,
  output logic [rsi_pkg::COLUMN_BITS-1:0]     out_column,
  output logic                                last_flag
);
  import rsi_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int SB = SAMPLE_BITS;
  localparam int AW = SB + 9;       // weighted sum plus bias
  localparam int YW = SB + 7;       // sum / 4
  localparam int MW = YW - 6;       // reciprocal of 125
  localparam int LW = 16;           // low split of the multiply
  localparam int HW = YW - LW;
  localparam int PW = YW + MW;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / 64'(QUOT_DIVISOR));
  localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

  // Row memories
  logic [SB-1:0] mem_a [MAX_COLUMNS];
  logic [SB-1:0] mem_b [MAX_COLUMNS];
  logic          src_sel;           // 0: source row is A

  logic          rd_valid;
  logic [SB-1:0] rd_data;
  logic [CW-1:0] emit_col;

  // Tap window, win[0] newest
  logic [SB-1:0] win [WIN_TAPS];
  logic [2:0]    fill;
  logic [CW-1:0] col_cnt;
  logic          s0_valid;

  logic          s1_valid, s1_first;
  logic [CW-1:0] s1_col;
  logic [SB-1:0] s1_center;
  logic [AW-1:0] s1_acc;

  logic          s2_valid, s2_first;
  logic [CW-1:0] s2_col;
  logic [SB-1:0] s2_center;
  logic [YW-1:0] s2_y;
  logic [LW+MW-1:0] s2_pl;
  logic [HW+MW-1:0] s2_ph;

  logic          s3_valid, s3_first;
  logic [CW-1:0] s3_col;
  logic [SB-1:0] s3_center;
  logic [YW-1:0] s3_y;
  logic [MW-1:0] s3_q0;

  logic [AW-1:0] sum;
  logic [YW-1:0] y_in;
  logic [PW-1:0] prod;
  logic [YW-1:0] rem;
  logic [MW-1:0] quot;
  logic [SB-1:0] wr_val;
  logic          we_a, we_b;
  logic [CW-1:0] wa_a;
  logic [SB-1:0] wd_a;

  // Sweep writes go to the row that is not the source
  assign we_a = cmd.load_we || (s3_valid && src_sel);
  assign we_b = s3_valid && !src_sel;
  assign wa_a = cmd.load_we ? load_addr : s3_col;
  assign wd_a = cmd.load_we ? SB'(in_value) : wr_val;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[s3_col] <= wr_val;
    end
  end

  // Registered read of the source row
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= src_sel ? mem_b[rd_addr] : mem_a[rd_addr];
    end
    emit_col  <= rd_addr;
    last_flag <= cmd.rd_en && cmd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_sel      <= 1'b0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.row_init) begin
        src_sel <= 1'b0;
      end else if (cmd.swap) begin
        src_sel <= !src_sel;
      end
      rd_valid     <= cmd.rd_en && !cmd.emit;
      result_valid <= cmd.rd_en && cmd.emit;
    end
  end

  assign out_value  = VALUE_BITS'(rd_data);
  assign out_column = COLUMN_BITS'(emit_col);

  // Window shift; full after five taps
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      for (int i = WIN_TAPS - 1; i > 0; i--) begin
        win[i] <= win[i-1];
      end
      win[0] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      col_cnt  <= '0;
      s0_valid <= 1'b0;
    end else if (cmd.sweep_init) begin
      fill     <= '0;
      col_cnt  <= '0;
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= rd_valid && (fill == 3'(WIN_TAPS - 1));
      if (rd_valid && fill != 3'(WIN_TAPS - 1)) begin
        fill <= fill + 3'd1;
      end
      if (s0_valid) begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Weighted five-point sum with rounding bias
  assign sum = AW'(win[4]) * AW'(W_M2) + AW'(win[3]) * AW'(W_M1)
             + AW'(win[2]) * AW'(W_C0) + AW'(win[1]) * AW'(W_P1)
             + AW'(win[0]) * AW'(W_P2) + AW'(ROUND_BIAS);

  assign y_in = s1_acc[AW-1:2];
  assign prod = (PW'(s2_ph) << LW) + PW'(s2_pl);

  // Quotient correction: q0 is exact or one low
  assign rem  = s3_y - YW'(s3_q0) * YW'(QUOT_DIVISOR);
  assign quot = (rem >= YW'(QUOT_DIVISOR)) ? s3_q0 + MW'(1) : s3_q0;
  always_comb begin
    if (s3_first) begin
      wr_val = s3_center;
    end else if (quot > MW'(SAMPLE_MAX)) begin
      wr_val = SAMPLE_MAX;
    end else begin
      wr_val = SB'(quot);
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_col    <= col_cnt;
    s1_first  <= col_cnt == '0;
    s1_center <= win[2];
    s1_acc    <= sum;

    s2_col    <= s1_col;
    s2_first  <= s1_first;
    s2_center <= s1_center;
    s2_y      <= y_in;
    s2_pl     <= (LW+MW)'(y_in[LW-1:0]) * (LW+MW)'(RECIP);
    s2_ph     <= (HW+MW)'(y_in[YW-1:LW]) * (HW+MW)'(RECIP);

    s3_col    <= s2_col;
    s3_first  <= s2_first;
    s3_center <= s2_center;
    s3_y      <= s2_y;
    s3_q0     <= MW'(prod >> YW);
  end

  assign pipe_empty = !(rd_valid || s0_valid || s1_valid || s2_valid || s3_valid);

endmodule

### tb/row_stencil_iterator_tb.sv
// Testbench for row_stencil_iterator: loads rows, predicts the swept rows
// with its own fixed-point stencil, and checks every emitted column.
// Depends on rsi_pkg and the row_stencil_iterator RTL.
module row_stencil_iterator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int MAX_COLS      = DEF_MAX_COLUMNS;
  localparam int SAMPLE_TARGET = 310;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  // Indexes with no register behind them
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  // Stencil weights over 500, tap j-2 first
  localparam longint unsigned TAP_M2 = 160;
  localparam longint unsigned TAP_M1 = 155;
  localparam longint unsigned TAP_C0 = 100;
  localparam longint unsigned TAP_P1 = 60;
  localparam longint unsigned TAP_P2 = 25;
  localparam longint unsigned WEIGHT_TOTAL = 500;
  localparam longint unsigned HALF_TOTAL   = 250;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [VALUE_BITS-1:0]     in_value;
  logic                      result_valid;
  logic [VALUE_BITS-1:0]     out_value;
  logic [COLUMN_BITS-1:0]    out_column;
  logic                      last_flag;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  row_stencil_iterator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_value(in_value),
    .result_valid(result_valid), .out_value(out_value), .out_column(out_column),
    .last_flag(last_flag), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [COLUMN_BITS-1:0] column;
    logic                   last;
  } column_result_t;

  // Expected columns, oldest first
  column_result_t pending_columns[$];

  // Mirror of the block: loaded row, registers, pinned expectations
  logic [VALUE_BITS-1:0]      row_store    [MAX_COLS];
  bit                         pinned       [MAX_COLS];
  logic [VALUE_BITS-1:0]      pinned_value [MAX_COLS];
  int unsigned                loaded = 0;
  logic [ROW_LENGTH_BITS-1:0] row_length_cfg = ROW_LENGTH_RESET;
  logic [ITER_BITS-1:0]       sweep_cfg = ITERATION_COUNT_RESET;

  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;

  // Directed stimulus: register writes and samples; exp is the column's
  // result where it is plain (unswept rows, fixed column 0, all-zero rows)
  typedef enum logic { STEP_WRITE, STEP_SAMPLE } step_kind_t;
  typedef struct {
    step_kind_t                kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [VALUE_BITS-1:0]     value;
    bit                        has_exp;
    logic [VALUE_BITS-1:0]     exp;
  } dir_step_t;

  localparam int N_DIRECTED = 32;
  const dir_step_t directed_steps [N_DIRECTED] = '{
    // length 0 with high junk bits acts as 3; no sweeps leaves the row as is
    '{STEP_WRITE,  REG_ROW_LENGTH,      16'hFF80, 24'h000000, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_ITERATION_COUNT, 16'h0000, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h800000, 1'b1, 24'h800000},
    // most sweeps on the shortest row
    '{STEP_WRITE,  REG_ITERATION_COUNT, 16'hFFFF, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h400000, 1'b0, 24'h000000},
    // length above range, then cut short mid-row below the loaded count
    '{STEP_WRITE,  REG_ROW_LENGTH,      16'h007F, 24'h000000, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_ITERATION_COUNT, 16'h0001, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h123456, 1'b1, 24'h123456},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'hFEDCBA, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h0F0F0F, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'hF0F0F0, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000001, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_ROW_LENGTH,      16'h0004, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h7FFFFF, 1'b0, 24'h000000},
    // writes to spare indexes must not disturb either register
    '{STEP_WRITE,  REG_SPARE_2,         16'h0005, 24'h000000, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_SPARE_3,         16'hFFFF, 24'h000000, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_ITERATION_COUNT, 16'h0000, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000001, 1'b1, 24'h000001},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'hAAAAAA, 1'b1, 24'hAAAAAA},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h555555, 1'b1, 24'h555555},
    // all-zero row stays zero under sweeps
    '{STEP_WRITE,  REG_ITERATION_COUNT, 16'h0002, 24'h000000, 1'b0, 24'h000000},
    '{STEP_WRITE,  REG_ROW_LENGTH,      16'h0005, 24'h000000, 1'b0, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000},
    '{STEP_SAMPLE, REG_ROW_LENGTH,      16'h0000, 24'h000000, 1'b1, 24'h000000}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("row_stencil_iterator: mismatch");
    $finish;
  end

  // Row length as the block uses it: clamped to 3..MAX_COLS
  function automatic int unsigned effective_length();
    if (row_length_cfg < MIN_LENGTH) return MIN_LENGTH;
    if (row_length_cfg > MAX_COLS) return MAX_COLS;
    return 32'(row_length_cfg);
  endfunction

  // Takes one accepted sample; on row completion runs the sweeps and
  // queues one expected result per column
  function automatic void stencil_predict(logic [VALUE_BITS-1:0] v, bit has_exp,
                                          logic [VALUE_BITS-1:0] exp_v);
    int unsigned len;
    longint unsigned acc;
    logic [VALUE_BITS-1:0] cur [MAX_COLS];
    logic [VALUE_BITS-1:0] nxt [MAX_COLS];
    column_result_t res;
    len = effective_length();
    if (loaded < MAX_COLS) begin
      row_store[loaded] = v;
      pinned[loaded] = has_exp;
      pinned_value[loaded] = exp_v;
      loaded++;
    end
    if (loaded < len) return;

    // Jacobi sweeps, periodic wrap, column 0 held
    cur = row_store;
    nxt = row_store;
    for (int unsigned s = 0; s < sweep_cfg; s++) begin
      nxt[0] = cur[0];
      for (int unsigned j = 1; j < len; j++) begin
        acc = TAP_M2 * 64'(cur[(j + len - 2) % len])
            + TAP_M1 * 64'(cur[(j + len - 1) % len])
            + TAP_C0 * 64'(cur[j]) + TAP_P1 * 64'(cur[(j + 1) % len])
            + TAP_P2 * 64'(cur[(j + 2) % len]);
        acc = (acc + HALF_TOTAL) / WEIGHT_TOTAL;
        if (acc > 64'(VALUE_MAX)) acc = 64'(VALUE_MAX);
        nxt[j] = acc[VALUE_BITS-1:0];
      end
      cur = nxt;
    end

    for (int unsigned j = 0; j < len; j++) begin
      res.value  = pinned[j] ? pinned_value[j] : cur[j];
      res.column = COLUMN_BITS'(j);
      res.last   = (j + 1 == len);
      pending_columns.push_back(res);
    end
    foreach (pinned[k]) pinned[k] = 1'b0;
    loaded = 0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: every strobe must match the oldest expected column
  always @(posedge clk) begin
    column_result_t want;
    if (!rst && result_valid !== 1'b0) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("unexpected result, column", 32'(out_column), 0);
      end else begin
        want = pending_columns.pop_front();
        if (out_value !== want.value) begin
          report_mismatch("out_value", 32'(out_value), 32'(want.value));
        end
        if (out_column !== want.column) begin
          report_mismatch("out_column", 32'(out_column), 32'(want.column));
        end
        if (last_flag !== want.last) begin
          report_mismatch("last_flag", 32'(last_flag), 32'(want.last));
        end
      end
    end
  end

  // Drop start and wait until the block has nothing left to emit
  task automatic settle_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_columns.size() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Idle the sender for the requested gap, with start low and in_value randomised
  task automatic hold_off(int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    start <= 1'b0;
    in_value <= VALUE_BITS'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one sample and wait until the block takes it
  task automatic send_sample(logic [VALUE_BITS-1:0] v, bit has_exp,
                             logic [VALUE_BITS-1:0] exp_v);
    @(negedge clk);
    start <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    stencil_predict(v, has_exp, exp_v);
    samples_sent++;
  endtask

  // Register write, only once the block is idle
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    settle_idle();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    wr_data <= CFG_DATA_BITS'($urandom);
    case (idx)
      REG_ROW_LENGTH:      row_length_cfg = data[ROW_LENGTH_BITS-1:0];
      REG_ITERATION_COUNT: sweep_cfg = data;
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VALUE_MAX;
      2: return VALUE_MAX - VALUE_BITS'($urandom_range(0, 255));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned pick;
    int unsigned rows;
    int unsigned len;
    bit steady;
    logic [CFG_DATA_BITS-1:0] cfg_word;

    rst = 1'b1;
    start = 1'b0;
    in_value = '0;
    wr_en = 1'b0;
    wr_index = REG_ROW_LENGTH;
    wr_data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // One full row under the reset register values
    for (int k = 0; k < MAX_COLS; k++) begin
      hold_off(sender_gap());
      send_sample(random_sample(), 1'b0, '0);
    end

    // Directed corners
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        hold_off(sender_gap());
        send_sample(directed_steps[i].value, directed_steps[i].has_exp, directed_steps[i].exp);
      end
    end

    // Random phases: new settings, then a few complete rows
    while (samples_sent < SAMPLE_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        cfg_word = CFG_DATA_BITS'($urandom);
        if (pick == 0) cfg_word[6:0] = 7'($urandom_range(65, 127));
        else if (pick == 1) cfg_word[6:0] = 7'(MAX_COLS);
        else if (pick == 2) cfg_word[6:0] = 7'($urandom_range(0, 2));
        else cfg_word[6:0] = 7'($urandom_range(3, 12));
        write_reg(REG_ROW_LENGTH, cfg_word);
      end
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 9) == 0) cfg_word = CFG_DATA_BITS'($urandom_range(7, 40));
        else cfg_word = CFG_DATA_BITS'($urandom_range(0, 6));
        write_reg(REG_ITERATION_COUNT, cfg_word);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_BITS'($urandom));
      end
      rows = $urandom_range(1, 3);
      repeat (rows) begin
        steady = ($urandom_range(0, 3) == 0);
        len = effective_length();
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 24) == 0) settle_idle();
          else if (!steady) hold_off(sender_gap());
          send_sample(random_sample(), 1'b0, '0);
        end
      end
    end

    settle_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("row_stencil_iterator: match");
    end else begin
      $display("row_stencil_iterator: mismatch");
    end
    $finish;
  end

endmodule
